>>> src/pig_pkg.sv
// Shared constants, types and the luminance threshold table for the grayscale path.
package pig_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned LUMA_W = 24;
  localparam int unsigned LEVELS = 256;

  localparam logic [15:0] WEIGHT_R = 16'd13933;
  localparam logic [15:0] WEIGHT_G = 16'd46871;
  localparam logic [15:0] WEIGHT_B = 16'd4732;

  localparam logic [63:0] LUMA_FULL   = 64'd16711680;
  localparam logic [63:0] LINEAR_MAX  = (64'd31308 * LUMA_FULL) / 64'd10000000;
  localparam logic [63:0] LINEAR_GAIN = 64'd1292;
  localparam logic [63:0] LINEAR_DIV  = 64'd6553600;
  localparam logic [31:0] POWER_SCALE = 32'd10761;

  typedef enum logic {
    MODE_INVERT = 1'b0,
    MODE_GRAY   = 1'b1
  } op_mode_e;

  typedef logic [319:0] wide_t;
  typedef logic [LEVELS-1:0][LUMA_W-1:0] thresh_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  function automatic wide_t pow_wide(input logic [63:0] base, input int unsigned n);
    wide_t acc;
    acc = wide_t'(1);
    for (int unsigned i = 0; i < n; i++) begin
      acc = acc * wide_t'(base);
    end
    return acc;
  endfunction

  // smallest luminance reaching each output level
  function automatic thresh_t build_thresholds();
    thresh_t     t;
    wide_t       scale12;
    wide_t       lhs;
    wide_t       rhs;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic        hit;
    scale12 = pow_wide(64'(POWER_SCALE), 12);
    for (int unsigned k = 0; k < LEVELS; k++) begin
      lhs = pow_wide(64'(40 * k + 561), 12) * pow_wide(LUMA_FULL, 5);
      lo  = 64'd0;
      hi  = LUMA_FULL;
      for (int unsigned it = 0; it < LUMA_W + 1; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (mid <= LINEAR_MAX) begin
            hit = (mid * LINEAR_GAIN) >= (64'(k) * LINEAR_DIV);
          end else begin
            rhs = scale12 * pow_wide(mid, 5);
            hit = lhs <= rhs;
          end
          if (hit) begin
            hi = mid;
          end else begin
            lo = mid + 64'd1;
          end
        end
      end
      t[k] = lo[LUMA_W-1:0];
    end
    return t;
  endfunction

  localparam thresh_t THRESHOLDS = build_thresholds();

endpackage

>>> src/pig_luma.sv
// Weighted sum of the colour channels into a 24-bit luminance.
module pig_luma
  import pig_pkg::*;
(
  input  pixel_t            pixel_i,
  output logic [LUMA_W-1:0] luma_o
);

  logic [LUMA_W-1:0] part_r;
  logic [LUMA_W-1:0] part_g;
  logic [LUMA_W-1:0] part_b;

  assign part_r = LUMA_W'(pixel_i.red)   * LUMA_W'(WEIGHT_R);
  assign part_g = LUMA_W'(pixel_i.green) * LUMA_W'(WEIGHT_G);
  assign part_b = LUMA_W'(pixel_i.blue)  * LUMA_W'(WEIGHT_B);
  assign luma_o = part_r + part_g + part_b;

endmodule

>>> src/pig_level.sv
// Gamma-encoded gray level from luminance by threshold compare and bisection.
module pig_level
  import pig_pkg::*;
(
  input  logic [LUMA_W-1:0] luma_i,
  output logic [CHAN_W-1:0] level_o
);

  logic [LEVELS-1:0] therm;

  always_comb begin
    for (int unsigned k = 0; k < LEVELS; k++) begin
      therm[k] = luma_i >= THRESHOLDS[k];
    end
  end

  always_comb begin
    logic [CHAN_W-1:0] idx;
    logic [CHAN_W-1:0] cand;
    idx = '0;
    for (int b = CHAN_W - 1; b >= 0; b--) begin
      cand = idx | (CHAN_W'(1) << b);
      if (therm[cand]) begin
        idx = cand;
      end
    end
    level_o = idx;
  end

endmodule

>>> src/pixel_invert_or_gamma_grayscale.sv
// Top level: pixel invert or sRGB grayscale stage with input and result registers.
// Each word is registered in the input stage, then its result in the result stage.
// Throughput: one word per cycle while the output is not stalled.
// The gray level comes from a constant threshold table searched in one pass
// after the luminance sum.
// Reset clears both stage valids and sets the mode to invert; the
// configuration port is always ready.
module pixel_invert_or_gamma_grayscale
  import pig_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CHAN_W-1:0] blue_in_i,
  input  logic [CHAN_W-1:0] green_in_i,
  input  logic [CHAN_W-1:0] red_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAN_W-1:0] blue_out_o,
  output logic [CHAN_W-1:0] green_out_o,
  output logic [CHAN_W-1:0] red_out_o
);

  op_mode_e          mode_q;
  logic              s1_valid_q;
  pixel_t            s1_pix_q;
  op_mode_e          s1_mode_q;
  logic              out_valid_q;
  pixel_t            out_pix_q;
  op_mode_e          out_mode_q;
  pixel_t            res_d;
  logic              out_ready;
  logic              s1_ready;
  logic [LUMA_W-1:0] luma;
  logic [CHAN_W-1:0] level;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_INVERT;
    end else if (cfg_valid_i) begin
      mode_q <= op_mode_e'(cfg_data_i);
    end
  end

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_pix_q  <= '{blue: blue_in_i, green: green_in_i, red: red_in_i};
      s1_mode_q <= mode_q;
    end
  end

  pig_luma u_luma (
    .pixel_i (s1_pix_q),
    .luma_o  (luma)
  );

  pig_level u_level (
    .luma_i  (luma),
    .level_o (level)
  );

  always_comb begin
    unique case (s1_mode_q)
      MODE_GRAY: res_d = '{blue: level, green: level, red: level};
      default:   res_d = ~s1_pix_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_pix_q  <= res_d;
      out_mode_q <= s1_mode_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign blue_out_o  = out_pix_q.blue;
  assign green_out_o = out_pix_q.green;
  assign red_out_o   = out_pix_q.red;

  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_mode_q == MODE_GRAY |->
      out_pix_q.blue == out_pix_q.green && out_pix_q.green == out_pix_q.red)
    else $error("gray word with unequal channels");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_ready |=> s1_valid_q && $stable(s1_pix_q) && $stable(s1_mode_q))
    else $error("input stage changed while blocked");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a full pipeline");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(!out_stall_i))
    else $error("result word dropped without being taken");

endmodule
